// ===== rtl/core/keyed_hourly_usage_counter_table_assert.svh =====
// Assertion macros for the keyed hourly usage counter table.
`ifndef KEYED_HOURLY_USAGE_COUNTER_TABLE_ASSERT_SVH
`define KEYED_HOURLY_USAGE_COUNTER_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every clock edge outside reset.
`define KHUC_ASSERT_NOW(lbl, en, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (en) |-> (expr)) \
        else $error("khuc assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define KHUC_ASSERT_NEXT(lbl, en, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (en) |=> (expr)) \
        else $error("khuc assertion failed");

`else

`define KHUC_ASSERT_NOW(lbl, en, expr)
`define KHUC_ASSERT_NEXT(lbl, en, expr)

`endif

`endif

// ===== rtl/core/khuc_pkg.sv =====
// Shared constants and types for the keyed hourly usage counter table.
package khuc_pkg;

    // Default sizing of the table.
    localparam int KHUC_NUM_ENTRIES = 20;
    localparam int KHUC_KEY_CHARS   = 31;
    localparam int KHUC_COUNT_BITS  = 32;

    // Hours in a day and the highest hour bucket.
    localparam int         HOURS     = 24;
    localparam logic [4:0] LAST_HOUR = 5'd23;

    // Port field widths.
    localparam int KEY_CHAR_W = 7;
    localparam int HOUR_W     = 5;
    localparam int INDEX_W    = 5;
    localparam int OUTCOME_W  = 2;
    localparam int COUNT_W    = 32;

    // Result outcome codes.
    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_FOUND   = 2'd0,
        OUTCOME_CREATED = 2'd1,
        OUTCOME_FULL    = 2'd2
    } outcome_t;

endpackage

// ===== rtl/core/keyed_hourly_usage_counter_table.sv =====
// Top level of the keyed hourly usage counter table: sequencer, stores and result register.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_key_char, s_last_char, s_hour_of_day
//  m_       out        m_valid / m_ready    m_entry_index, m_outcome, m_total_count,
//                                           m_hour_count
//
// A character that is not last is only staged. On the last character the sequencer walks the
// stored entries with one compare unit, visiting slots in order and checking the length and up
// to KEY_CHARS characters of each. A hit updates the entry's total and hour counter; a miss
// with room creates an entry, copies the key and clears its hour counters; a miss with the table
// full gives OUTCOME_FULL. The result is then loaded into the output register.
// Reset clears the sequencer, the fill count, the staging length and the output valid flag.
// s_ready is low from the last character until the result is loaded into the output register,
// and a result stalled on m_ready holds the sequencer in its final step.
`include "keyed_hourly_usage_counter_table_assert.svh"

module keyed_hourly_usage_counter_table
    import khuc_pkg::*;
#(
    parameter int NUM_ENTRIES = KHUC_NUM_ENTRIES,
    parameter int KEY_CHARS   = KHUC_KEY_CHARS,
    parameter int COUNT_BITS  = KHUC_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KEY_CHAR_W-1:0] s_key_char,
    input  logic                  s_last_char,
    input  logic [HOUR_W-1:0]     s_hour_of_day,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_W-1:0]    m_entry_index,
    output logic [OUTCOME_W-1:0]  m_outcome,
    output logic [COUNT_W-1:0]    m_total_count,
    output logic [COUNT_W-1:0]    m_hour_count
);

    // Derived widths.
    localparam int KEY_DEPTH  = NUM_ENTRIES * KEY_CHARS;
    localparam int HOUR_DEPTH = NUM_ENTRIES * HOURS;
    localparam int SW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int UW  = $clog2(NUM_ENTRIES + 1);
    localparam int IW  = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int LW  = $clog2(KEY_CHARS + 1);
    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KBW = $clog2(KEY_DEPTH + 1);
    localparam int HAW = $clog2(HOUR_DEPTH);
    localparam int HBW = $clog2(HOUR_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [7:0] {
        ST_COLLECT = 8'b0000_0001,
        ST_SLOT    = 8'b0000_0010,
        ST_CMP     = 8'b0000_0100,
        ST_UPD     = 8'b0000_1000,
        ST_NEW     = 8'b0001_0000,
        ST_COPY    = 8'b0010_0000,
        ST_CLR     = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    // Storage arrays.
    logic [KEY_CHAR_W-1:0] stage_mem [KEY_CHARS];
    logic [KEY_CHAR_W-1:0] key_mem   [KEY_DEPTH];
    logic [LW-1:0]         len_mem   [NUM_ENTRIES];
    logic [COUNT_BITS-1:0] tot_mem   [NUM_ENTRIES];
    logic [COUNT_BITS-1:0] hour_mem  [HOUR_DEPTH];

    // Registered read data.
    logic [KEY_CHAR_W-1:0] stage_q;
    logic [KEY_CHAR_W-1:0] key_q;
    logic [LW-1:0]         len_q;
    logic [COUNT_BITS-1:0] tot_q;
    logic [COUNT_BITS-1:0] hour_q;

    // Control and working registers.
    state_t                state_reg, state_next;
    logic [LW-1:0]         stage_len_reg, stage_len_next;
    logic [LW-1:0]         key_len_reg, key_len_next;
    logic [HOUR_W-1:0]     hour_reg, hour_next;
    logic [UW-1:0]         slot_reg, slot_next;
    logic [UW-1:0]         used_reg, used_next;
    logic [KBW-1:0]        base_reg, base_next;
    logic [HBW-1:0]        hbase_reg, hbase_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [HOUR_W-1:0]     hc_reg, hc_next;
    logic [INDEX_W-1:0]    res_idx_reg, res_idx_next;
    outcome_t              res_oc_reg, res_oc_next;
    logic [COUNT_BITS-1:0] res_tot_reg, res_tot_next;
    logic [COUNT_BITS-1:0] res_hr_reg, res_hr_next;
    logic                  m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]    m_idx_reg, m_idx_next;
    logic [OUTCOME_W-1:0]  m_oc_reg, m_oc_next;
    logic [COUNT_W-1:0]    m_tot_reg, m_tot_next;
    logic [COUNT_W-1:0]    m_hr_reg, m_hr_next;

    // Datapath signals.
    logic                  idx_last;
    logic [IW-1:0]         rd_idx;
    logic [KBW-1:0]        key_raddr;
    logic [KBW-1:0]        key_waddr;
    logic [HBW-1:0]        hour_raddr;
    logic [HBW-1:0]        hour_waddr;
    logic [COUNT_BITS-1:0] tot_inc;
    logic [COUNT_BITS-1:0] hr_inc;
    logic                  stage_we;
    logic                  key_we;
    logic                  len_we;
    logic                  tot_we;
    logic [COUNT_BITS-1:0] tot_wdata;
    logic                  hour_we;
    logic [COUNT_BITS-1:0] hour_wdata;

    assign s_ready       = (state_reg == ST_COLLECT);
    assign m_valid       = m_valid_reg;
    assign m_entry_index = m_idx_reg;
    assign m_outcome     = m_oc_reg;
    assign m_total_count = m_tot_reg;
    assign m_hour_count  = m_hr_reg;

    // The character pointer stops at the last staged character; reads run one ahead of it.
    assign idx_last  = ((LW'(idx_reg) + LW'(1)) == key_len_reg);
    assign rd_idx    = ((state_reg == ST_CMP || state_reg == ST_COPY) && !idx_last) ?
                       idx_reg + IW'(1) : ((state_reg == ST_CMP || state_reg == ST_COPY) ?
                       idx_reg : '0);
    assign key_raddr  = base_reg + KBW'(rd_idx);
    assign key_waddr  = base_reg + KBW'(idx_reg);
    assign hour_raddr = hbase_reg + HBW'(hour_reg);

    // Shared saturating incrementers.
    assign tot_inc = (tot_q == COUNT_MAX) ? tot_q : tot_q + COUNT_ONE;
    assign hr_inc  = (hour_q == COUNT_MAX) ? hour_q : hour_q + COUNT_ONE;

    // Staging buffer: written while characters arrive, read during compare and copy.
    always_ff @(posedge aclk) begin
        if (stage_we) begin
            stage_mem[stage_len_reg[IW-1:0]] <= s_key_char;
        end
        stage_q <= stage_mem[rd_idx];
    end

    // Stored key characters.
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr[KAW-1:0]] <= stage_q;
        end
        key_q <= key_mem[key_raddr[KAW-1:0]];
    end

    // Per-entry key length and total.
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[slot_reg[SW-1:0]] <= key_len_reg;
        end
        if (tot_we) begin
            tot_mem[slot_reg[SW-1:0]] <= tot_wdata;
        end
        len_q <= len_mem[slot_reg[SW-1:0]];
        tot_q <= tot_mem[slot_reg[SW-1:0]];
    end

    // Per-entry hour counters.
    always_ff @(posedge aclk) begin
        if (hour_we) begin
            hour_mem[hour_waddr[HAW-1:0]] <= hour_wdata;
        end
        hour_q <= hour_mem[hour_raddr[HAW-1:0]];
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        stage_len_next = stage_len_reg;
        key_len_next   = key_len_reg;
        hour_next      = hour_reg;
        slot_next      = slot_reg;
        used_next      = used_reg;
        base_next      = base_reg;
        hbase_next     = hbase_reg;
        idx_next       = idx_reg;
        hc_next        = hc_reg;
        res_idx_next   = res_idx_reg;
        res_oc_next    = res_oc_reg;
        res_tot_next   = res_tot_reg;
        res_hr_next    = res_hr_reg;
        m_valid_next   = m_valid_reg;
        m_idx_next     = m_idx_reg;
        m_oc_next      = m_oc_reg;
        m_tot_next     = m_tot_reg;
        m_hr_next      = m_hr_reg;
        stage_we       = 1'b0;
        key_we         = 1'b0;
        len_we         = 1'b0;
        tot_we         = 1'b0;
        tot_wdata      = tot_inc;
        hour_we        = 1'b0;
        hour_wdata     = hr_inc;
        hour_waddr     = hour_raddr;

        // The output register empties on a completed transfer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_COLLECT: begin
                if (s_valid) begin
                    // Characters past the staging depth are dropped.
                    if (stage_len_reg < LW'(KEY_CHARS)) begin
                        stage_we       = 1'b1;
                        stage_len_next = stage_len_reg + LW'(1);
                    end
                    if (s_last_char) begin
                        key_len_next   = (stage_len_reg < LW'(KEY_CHARS)) ?
                                         stage_len_reg + LW'(1) : stage_len_reg;
                        stage_len_next = '0;
                        hour_next      = (s_hour_of_day > LAST_HOUR) ? LAST_HOUR : s_hour_of_day;
                        slot_next      = '0;
                        base_next      = '0;
                        hbase_next     = '0;
                        state_next     = ST_SLOT;
                    end
                end
            end
            ST_SLOT: begin
                idx_next = '0;
                if (slot_reg != used_reg) begin
                    state_next = ST_CMP;
                end else if (used_reg == UW'(NUM_ENTRIES)) begin
                    res_idx_next = '0;
                    res_oc_next  = OUTCOME_FULL;
                    res_tot_next = '0;
                    res_hr_next  = '0;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_NEW;
                end
            end
            ST_CMP: begin
                // Length and one character are checked per cycle.
                if (len_q != key_len_reg || key_q != stage_q) begin
                    slot_next  = slot_reg + UW'(1);
                    base_next  = base_reg + KBW'(KEY_CHARS);
                    hbase_next = hbase_reg + HBW'(HOURS);
                    state_next = ST_SLOT;
                end else if (idx_last) begin
                    state_next = ST_UPD;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_UPD: begin
                tot_we       = 1'b1;
                hour_we      = 1'b1;
                res_idx_next = INDEX_W'(slot_reg);
                res_oc_next  = OUTCOME_FOUND;
                res_tot_next = tot_inc;
                res_hr_next  = hr_inc;
                state_next   = ST_OUT;
            end
            ST_NEW: begin
                // A new entry starts with a total of one after its first count.
                len_we     = 1'b1;
                tot_we     = 1'b1;
                tot_wdata  = COUNT_ONE;
                idx_next   = '0;
                state_next = ST_COPY;
            end
            ST_COPY: begin
                key_we = 1'b1;
                if (idx_last) begin
                    hc_next    = '0;
                    state_next = ST_CLR;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_CLR: begin
                // Clear all hour counters of the new entry, counting the requested hour once.
                hour_we    = 1'b1;
                hour_waddr = hbase_reg + HBW'(hc_reg);
                hour_wdata = (hc_reg == hour_reg) ? COUNT_ONE : '0;
                if (hc_reg == LAST_HOUR) begin
                    used_next    = used_reg + UW'(1);
                    res_idx_next = INDEX_W'(slot_reg);
                    res_oc_next  = OUTCOME_CREATED;
                    res_tot_next = COUNT_ONE;
                    res_hr_next  = COUNT_ONE;
                    state_next   = ST_OUT;
                end else begin
                    hc_next = hc_reg + HOUR_W'(1);
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    m_oc_next    = res_oc_reg;
                    m_tot_next   = COUNT_W'(res_tot_reg);
                    m_hr_next    = COUNT_W'(res_hr_reg);
                    state_next   = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COLLECT;
            stage_len_reg <= '0;
            used_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            stage_len_reg <= stage_len_next;
            used_reg      <= used_next;
            m_valid_reg   <= m_valid_next;
        end
        key_len_reg <= key_len_next;
        hour_reg    <= hour_next;
        slot_reg    <= slot_next;
        base_reg    <= base_next;
        hbase_reg   <= hbase_next;
        idx_reg     <= idx_next;
        hc_reg      <= hc_next;
        res_idx_reg <= res_idx_next;
        res_oc_reg  <= res_oc_next;
        res_tot_reg <= res_tot_next;
        res_hr_reg  <= res_hr_next;
        m_idx_reg   <= m_idx_next;
        m_oc_reg    <= m_oc_next;
        m_tot_reg   <= m_tot_next;
        m_hr_reg    <= m_hr_next;
    end

    // Checks on the sequencer and the results it produces.
    `KHUC_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= UW'(NUM_ENTRIES))
    `KHUC_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_last_char, !s_ready)
    `KHUC_ASSERT_NOW(a_created_counts, m_valid && (m_outcome == OUTCOME_CREATED),
                     (m_total_count == 32'd1) && (m_hour_count == 32'd1))
    `KHUC_ASSERT_NOW(a_full_clean, m_valid && (m_outcome == OUTCOME_FULL),
                     (m_entry_index == '0) && (m_total_count == '0) && (m_hour_count == '0))
    `KHUC_ASSERT_NOW(a_hour_le_total, m_valid && (m_outcome == OUTCOME_FOUND),
                     m_hour_count <= m_total_count)

endmodule
